### src/jsct_pkg.sv
// Shared constants, codes and types for the job schedule completion time block.
package jsct_pkg;

  localparam int MAX_JOBS = 32;
  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  localparam int ARRIVAL_W = 14;
  localparam int BURST_W = 8;
  localparam int PRIO_W = 3;
  localparam int TIME_W = 14;
  localparam int TURN_W = 15;
  localparam int JOB_INDEX_W = 6;
  localparam int MODE_W = 2;
  localparam int QUANTUM_W = 8;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(5);

  // scheduling disciplines
  localparam logic [MODE_W-1:0] MODE_LOAD_ORDER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SHORTEST = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PRIORITY = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ROUND_ROBIN = 2'd3;

  // configuration register indexes
  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_QUANTUM = 1'b1;

  typedef struct packed {
    logic [ARRIVAL_W-1:0] arrival;
    logic [BURST_W-1:0]   burst;
    logic [PRIO_W-1:0]    prio;
    logic [BURST_W-1:0]   remaining;
    logic                 finished;
  } job_entry_t;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [QUANTUM_W-1:0] quantum;
    logic [TIME_W-1:0]    clock_now;
    logic [BURST_W-1:0]   remaining;
    logic [BURST_W-1:0]   cand_burst;
    logic [PRIO_W-1:0]    cand_prio;
    logic [BURST_W-1:0]   pick_burst;
    logic [PRIO_W-1:0]    pick_prio;
  } alu_in_t;

  typedef struct packed {
    logic                 better;
    logic [TIME_W-1:0]    new_clock;
    logic [BURST_W-1:0]   new_remaining;
    logic                 finish;
  } alu_out_t;

endpackage

### src/jsct_table.sv
// Job table: per-job arrival, burst, priority, remaining time and finished flag.
module jsct_table (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load_en,
  input  logic [jsct_pkg::IDX_W-1:0]     load_addr,
  input  logic [jsct_pkg::ARRIVAL_W-1:0] load_arrival,
  input  logic [jsct_pkg::BURST_W-1:0]   load_burst,
  input  logic [jsct_pkg::PRIO_W-1:0]    load_prio,
  input  logic                           upd_en,
  input  logic [jsct_pkg::IDX_W-1:0]     upd_addr,
  input  logic [jsct_pkg::BURST_W-1:0]   upd_remaining,
  input  logic                           upd_finished,
  input  logic                           clear_finished,
  input  logic [jsct_pkg::IDX_W-1:0]     rd_addr,
  output jsct_pkg::job_entry_t           rd_entry
);

  logic [jsct_pkg::ARRIVAL_W-1:0] arrival_store [jsct_pkg::MAX_JOBS];
  logic [jsct_pkg::BURST_W-1:0]   burst_store [jsct_pkg::MAX_JOBS];
  logic [jsct_pkg::PRIO_W-1:0]    priority_store [jsct_pkg::MAX_JOBS];
  logic [jsct_pkg::BURST_W-1:0]   remaining_store [jsct_pkg::MAX_JOBS];
  logic [jsct_pkg::MAX_JOBS-1:0]  finished_flags;

  always_ff @(posedge clk) begin
    if (load_en) begin
      arrival_store[load_addr] <= load_arrival;
      burst_store[load_addr] <= load_burst;
      priority_store[load_addr] <= load_prio;
      remaining_store[load_addr] <= load_burst;
    end else if (upd_en) begin
      remaining_store[upd_addr] <= upd_remaining;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_finished) begin
      finished_flags <= '0;
    end else if (upd_en) begin
      finished_flags[upd_addr] <= upd_finished;
    end
  end

  always_comb begin
    rd_entry.arrival = arrival_store[rd_addr];
    rd_entry.burst = burst_store[rd_addr];
    rd_entry.prio = priority_store[rd_addr];
    rd_entry.remaining = remaining_store[rd_addr];
    rd_entry.finished = finished_flags[rd_addr];
  end

endmodule

### src/jsct_alu.sv
// Shared step unit: key compare, time slice, saturating clock add.
module jsct_alu (
  input  jsct_pkg::alu_in_t  op,
  output jsct_pkg::alu_out_t res
);

  logic [jsct_pkg::QUANTUM_W-1:0] q;
  logic                           slice_cut;
  logic [jsct_pkg::BURST_W-1:0]   slice;
  logic [jsct_pkg::TIME_W:0]      sum;

  always_comb begin
    unique case (op.mode)
      jsct_pkg::MODE_SHORTEST: res.better = op.cand_burst < op.pick_burst;
      jsct_pkg::MODE_PRIORITY: res.better = op.cand_prio > op.pick_prio;
      default:                 res.better = 1'b0;
    endcase
  end

  always_comb begin
    q = (op.quantum == '0) ? jsct_pkg::QUANTUM_W'(1) : op.quantum;
    slice_cut = (op.mode == jsct_pkg::MODE_ROUND_ROBIN) && (op.remaining > q);
    slice = slice_cut ? q : op.remaining;
    sum = {1'b0, op.clock_now} + (jsct_pkg::TIME_W + 1)'(slice);
    res.new_clock = sum[jsct_pkg::TIME_W] ? jsct_pkg::TIME_MAX : sum[jsct_pkg::TIME_W-1:0];
    res.new_remaining = op.remaining - slice;
    res.finish = !slice_cut;
  end

endmodule

### src/job_schedule_completion_times_core.sv
// Top level: job loader, schedule sequencer and result output register.
//
// Jobs stream in one beat per cycle (arrival, burst, priority) and fill a
// table of up to MAX_JOBS entries; a beat that finds the table full is
// dropped. The beat with tlast set starts the schedule under the configured
// mode, and s_tready stays low until the last result of the batch has been
// issued. Results come out in completion order (job index, exit time,
// turnaround) with m_tlast on the final one. Timing is set by one table read
// port and one shared step unit: in load order, shortest burst and priority
// modes each completion costs one pass over the n loaded jobs followed by an
// execute step; round robin visits one table slot per cycle, including
// finished ones. Each emitted result also waits while the output register
// holds an untaken beat. Exit times saturate at 16383 while remaining times
// still count down. Mode and quantum are written through the cfg port
// (index 0 mode, index 1 quantum, reset 0 and 5); the user must write them
// only while idle, which the block itself does not enforce. A quantum of zero
// acts as one.
module job_schedule_completion_times_core (
  input  logic        clk,
  input  logic        rst,
  // job beats
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // arrival[13:0], burst[21:14], job_priority[24:22], zero pad
  input  logic        s_tlast,  // last_job
  // result beats
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // job_index[5:0], exit_time[19:6], turnaround[34:20], zero pad
  output logic        m_tlast,  // last_result
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_SCAN,
    S_EXEC,
    S_ROBIN
  } state_t;

  state_t state;

  logic [jsct_pkg::MODE_W-1:0]    mode;
  logic [jsct_pkg::QUANTUM_W-1:0] quantum;
  logic [jsct_pkg::CNT_W-1:0]     job_count;
  logic [jsct_pkg::CNT_W-1:0]     batch_size;
  logic [jsct_pkg::CNT_W-1:0]     done_count;
  logic [jsct_pkg::TIME_W-1:0]    clock_now;
  logic [jsct_pkg::IDX_W-1:0]     idx;
  logic [jsct_pkg::IDX_W-1:0]     pick;
  logic                           pick_valid;
  logic [jsct_pkg::BURST_W-1:0]   pick_burst;
  logic [jsct_pkg::PRIO_W-1:0]    pick_prio;

  logic [jsct_pkg::JOB_INDEX_W-1:0] out_index;
  logic [jsct_pkg::TIME_W-1:0]      out_exit;
  logic [jsct_pkg::TURN_W-1:0]      out_turn;

  jsct_pkg::job_entry_t entry;
  jsct_pkg::alu_in_t    alu_op;
  jsct_pkg::alu_out_t   alu_res;

  logic                         in_beat;
  logic                         table_room;
  logic                         out_free;
  logic [jsct_pkg::IDX_W-1:0]   rd_addr;
  logic [jsct_pkg::IDX_W-1:0]   last_idx;
  logic                         step_go;
  logic                         emit;
  logic                         final_emit;
  logic [jsct_pkg::TURN_W-1:0]  turn_calc;

  assign s_tready = (state == S_LOAD);
  assign cfg_ready = 1'b1;
  assign in_beat = s_tvalid && s_tready;
  assign table_room = job_count < jsct_pkg::CNT_W'(jsct_pkg::MAX_JOBS);
  assign out_free = !m_tvalid || m_tready;
  assign last_idx = jsct_pkg::IDX_W'(batch_size - jsct_pkg::CNT_W'(1));
  assign rd_addr = (state == S_EXEC) ? pick : idx;

  jsct_table u_table (
    .clk           (clk),
    .rst           (rst),
    .load_en       (in_beat && table_room),
    .load_addr     (job_count[jsct_pkg::IDX_W-1:0]),
    .load_arrival  (s_tdata[13:0]),
    .load_burst    (s_tdata[21:14]),
    .load_prio     (s_tdata[24:22]),
    .upd_en        (step_go),
    .upd_addr      (rd_addr),
    .upd_remaining (alu_res.new_remaining),
    .upd_finished  (alu_res.finish),
    .clear_finished(state == S_START),
    .rd_addr       (rd_addr),
    .rd_entry      (entry)
  );

  always_comb begin
    alu_op.mode = mode;
    alu_op.quantum = quantum;
    alu_op.clock_now = clock_now;
    alu_op.remaining = entry.remaining;
    alu_op.cand_burst = entry.burst;
    alu_op.cand_prio = entry.prio;
    alu_op.pick_burst = pick_burst;
    alu_op.pick_prio = pick_prio;
  end

  jsct_alu u_alu (
    .op (alu_op),
    .res(alu_res)
  );

  // A step commits only when its result, if any, can enter the output register.
  always_comb begin
    step_go = 1'b0;
    if (state == S_EXEC) begin
      step_go = out_free;
    end else if (state == S_ROBIN) begin
      step_go = !entry.finished && (!alu_res.finish || out_free);
    end
    emit = step_go && alu_res.finish;
    final_emit = emit && (done_count + jsct_pkg::CNT_W'(1) == batch_size);
    turn_calc = {1'b0, alu_res.new_clock} - {1'b0, entry.arrival};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      mode <= jsct_pkg::MODE_LOAD_ORDER;
      quantum <= jsct_pkg::QUANTUM_RESET;
      job_count <= '0;
      batch_size <= '0;
      done_count <= '0;
      clock_now <= '0;
      idx <= '0;
      pick_valid <= 1'b0;
      m_tvalid <= 1'b0;
      m_tlast <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          jsct_pkg::CFG_MODE:    mode <= cfg_data[jsct_pkg::MODE_W-1:0];
          jsct_pkg::CFG_QUANTUM: quantum <= cfg_data;
          default:               ;
        endcase
      end

      if (emit) begin
        m_tvalid <= 1'b1;
        m_tlast <= final_emit;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_LOAD: begin
          if (in_beat) begin
            if (table_room) begin
              job_count <= job_count + jsct_pkg::CNT_W'(1);
            end
            if (s_tlast) begin
              batch_size <= table_room ? job_count + jsct_pkg::CNT_W'(1) : job_count;
              state <= S_START;
            end
          end
        end
        S_START: begin
          clock_now <= '0;
          done_count <= '0;
          idx <= '0;
          pick_valid <= 1'b0;
          state <= (mode == jsct_pkg::MODE_ROUND_ROBIN) ? S_ROBIN : S_SCAN;
        end
        S_SCAN: begin
          // earlier job keeps ties: replace only on a strictly better key
          if (!entry.finished && (!pick_valid || alu_res.better)) begin
            pick_valid <= 1'b1;
          end
          if (idx == last_idx) begin
            state <= S_EXEC;
          end else begin
            idx <= idx + jsct_pkg::IDX_W'(1);
          end
        end
        S_EXEC: begin
          if (step_go) begin
            clock_now <= alu_res.new_clock;
            done_count <= done_count + jsct_pkg::CNT_W'(1);
            idx <= '0;
            pick_valid <= 1'b0;
            if (final_emit) begin
              job_count <= '0;
              state <= S_LOAD;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_ROBIN: begin
          if (step_go) begin
            clock_now <= alu_res.new_clock;
          end
          if (emit) begin
            done_count <= done_count + jsct_pkg::CNT_W'(1);
          end
          if (final_emit) begin
            job_count <= '0;
            state <= S_LOAD;
          end else if (entry.finished || step_go) begin
            idx <= (idx == last_idx) ? '0 : idx + jsct_pkg::IDX_W'(1);
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // candidate registers for the selection pass
  always_ff @(posedge clk) begin
    if (state == S_SCAN && !entry.finished && (!pick_valid || alu_res.better)) begin
      pick <= idx;
      pick_burst <= entry.burst;
      pick_prio <= entry.prio;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_index <= jsct_pkg::JOB_INDEX_W'(rd_addr);
      out_exit <= alu_res.new_clock;
      out_turn <= turn_calc;
    end
  end

  assign m_tdata = {5'b0, out_turn, out_exit, out_index};

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    job_count <= jsct_pkg::CNT_W'(jsct_pkg::MAX_JOBS))
    else $error("job count beyond table depth");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_EXEC || state == S_ROBIN) |-> done_count < batch_size)
    else $error("schedule running with every job already done");

  a_final_ends: assert property (@(posedge clk) disable iff (rst)
    final_emit |=> (state == S_LOAD && job_count == '0 && m_tvalid && m_tlast))
    else $error("final result did not return the block to loading");

  a_exec_pick: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> (pick_valid && !entry.finished))
    else $error("execute step without an unfinished pick");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !emit)
    else $error("result issued over an untaken beat");
`endif

endmodule
